@@ rtl/core/stereo_sad_disparity_defines.svh @@
// Assertion macros shared by the stereo disparity RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef STEREO_SAD_DISPARITY_DEFINES_SVH
`define STEREO_SAD_DISPARITY_DEFINES_SVH

// same-cycle implication
`define SADD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SADD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sadd_pkg.sv @@
// Package for the stereo SAD disparity block: sizes, constants and shared types.
// No dependencies.
`default_nettype none
package sadd_pkg;
   localparam int MAX_WIDTH   = 2048;
   localparam int DISPARITIES = 128;
   localparam int WIN         = 5;
   localparam int LINES       = 4;
   localparam int RCOLS       = DISPARITIES + 4;
   localparam int PIX_W       = 8;
   localparam int CFG_W       = 12;
   localparam int X_W         = 11;
   localparam int Y_W         = 12;
   localparam int DISP_W      = 7;
   localparam int SAD_W       = 13;
   localparam int STEP_W      = $clog2(RCOLS);
   localparam int WORD_W      = 2 * LINES * PIX_W;
   localparam int WIDTH_MIN   = 8;
   localparam int WIDTH_RESET = 640;
   localparam int ROW_MAX     = 4095;
   localparam int START_MIN   = 255;
   // floor(s/25) == (s*5243)>>17 for s <= 25*255
   localparam int RECIP       = 5243;
   localparam int RECIP_SHIFT = 17;

   typedef logic [WIN-1:0][PIX_W-1:0] column_type;

   typedef struct packed {
      column_type        lcol;
      column_type        rcol;
      logic              produce;
      logic              do_match;
      logic [X_W-1:0]    cx;
      logic [Y_W-1:0]    cy;
   } col_item_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;
endpackage
`default_nettype wire

@@ rtl/core/sadd_req_if.sv @@
// Input pixel channel: valid/ready plus left/right pixel and frame start.
// Depends on sadd_pkg.
`default_nettype none
interface sadd_req_if;
   logic                       valid;
   logic                       ready;
   logic [sadd_pkg::PIX_W-1:0] left_pixel;
   logic [sadd_pkg::PIX_W-1:0] right_pixel;
   logic                       frame_start;
   modport source (output valid, left_pixel, right_pixel, frame_start, input ready);
   modport sink   (input valid, left_pixel, right_pixel, frame_start, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sadd_rsp_if.sv @@
// Result channel: valid/ready plus disparity and centre coordinates.
// Depends on sadd_pkg.
`default_nettype none
interface sadd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sadd_pkg::DISP_W-1:0] disparity;
   logic [sadd_pkg::X_W-1:0]    centre_x;
   logic [sadd_pkg::Y_W-1:0]    centre_y;
   modport source (output valid, disparity, centre_x, centre_y, input ready);
   modport sink   (input valid, disparity, centre_x, centre_y, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sadd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sadd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/sadd_front.sv @@
// Front end: pixel counters, four-line stores, column assembly and classification.
// Depends on sadd_pkg, sadd_req_if and sadd_ram.
`default_nettype none
module sadd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [sadd_pkg::CFG_W-1:0]    width_cfg,
   sadd_req_if.sink                           req_bus,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output sadd_pkg::col_item_type             push_item
);
   localparam int XW = sadd_pkg::X_W;
   localparam int YW = sadd_pkg::Y_W;
   localparam int CW = sadd_pkg::CFG_W;
   localparam int PW = sadd_pkg::PIX_W;

   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic          b_valid_ff, b_valid_in;
   logic [XW-1:0] b_x_ff;
   logic [YW-1:0] b_y_ff;
   logic [PW-1:0] b_lp_ff, b_rp_ff;

   logic [CW-1:0] width;
   logic [XW-1:0] x_start, x_eff;
   logic [YW-1:0] y_eff;
   logic [CW-1:0] x_next;
   logic          accept, push;
   logic [sadd_pkg::WORD_W-1:0] rd_word, wr_word;
   logic [1:0]    slot;

   always_comb begin
      if (width_cfg < CW'(sadd_pkg::WIDTH_MIN)) begin
         width = CW'(sadd_pkg::WIDTH_MIN);
      end else if (width_cfg > CW'(sadd_pkg::MAX_WIDTH)) begin
         width = CW'(sadd_pkg::MAX_WIDTH);
      end else begin
         width = width_cfg;
      end
   end

   assign req_bus.ready = !b_valid_ff;
   assign accept = req_bus.valid && !b_valid_ff;
   assign push = b_valid_ff && push_ready;

   always_comb begin
      x_start = req_bus.frame_start ? '0 : col_ff;
      y_eff   = req_bus.frame_start ? '0 : row_ff;
      x_eff   = ({1'b0, x_start} >= width) ? '0 : x_start;
      x_next  = {1'b0, x_eff} + CW'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (x_next >= width) begin
            col_in = '0;
            row_in = (y_eff < YW'(sadd_pkg::ROW_MAX)) ? y_eff + YW'(1) : y_eff;
         end else begin
            col_in = x_next[XW-1:0];
            row_in = y_eff;
         end
      end
      b_valid_in = accept ? 1'b1 : (push ? 1'b0 : b_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_x_ff  <= x_eff;
         b_y_ff  <= y_eff;
         b_lp_ff <= req_bus.left_pixel;
         b_rp_ff <= req_bus.right_pixel;
      end
   end

   assign slot = b_y_ff[1:0];

   always_comb begin
      logic [1:0] s;
      wr_word = rd_word;
      wr_word[slot*PW +: PW] = b_lp_ff;
      wr_word[(sadd_pkg::LINES + slot)*PW +: PW] = b_rp_ff;
      for (int r = 0; r < sadd_pkg::LINES; r++) begin
         s = slot + 2'(r);
         push_item.lcol[r] = rd_word[s*PW +: PW];
         push_item.rcol[r] = rd_word[(sadd_pkg::LINES + s)*PW +: PW];
      end
      push_item.lcol[sadd_pkg::LINES] = b_lp_ff;
      push_item.rcol[sadd_pkg::LINES] = b_rp_ff;
      push_item.cx       = b_x_ff - XW'(2);
      push_item.cy       = b_y_ff - YW'(2);
      push_item.produce  = (b_x_ff >= XW'(2)) && (b_y_ff >= YW'(2));
      push_item.do_match = (b_y_ff >= YW'(4)) && (b_x_ff >= XW'(sadd_pkg::DISPARITIES + 3));
   end

   assign push_valid = b_valid_ff;

   sadd_ram #(
      .WIDTH(sadd_pkg::WORD_W),
      .DEPTH(sadd_pkg::MAX_WIDTH)
   ) u_lines (
      .clock (clock),
      .we    (push),
      .waddr (b_x_ff),
      .wdata (wr_word),
      .re    (accept),
      .raddr (x_eff),
      .rdata (rd_word)
   );
endmodule
`default_nettype wire

@@ rtl/core/sadd_queue.sv @@
// Two-entry queue of assembled columns between the front and back ends.
// Depends on sadd_pkg.
`default_nettype none
module sadd_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  sadd_pkg::col_item_type      push_item,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output sadd_pkg::col_item_type      pop_item
);
   sadd_pkg::col_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/sadd_back.sv @@
// Back end: sliding windows, one-shift-per-cycle SAD search and result register.
// Depends on sadd_pkg, sadd_rsp_if and the assertion macro header.
`default_nettype none
`include "stereo_sad_disparity_defines.svh"
module sadd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  sadd_pkg::col_item_type    pop_item,
   sadd_rsp_if.source                rsp_bus
);
   localparam int PW  = sadd_pkg::PIX_W;
   localparam int SW  = sadd_pkg::SAD_W;
   localparam int TW  = sadd_pkg::STEP_W;
   localparam int DW  = sadd_pkg::DISP_W;
   localparam int MW  = SW + SW;
   localparam int WN  = sadd_pkg::WIN;
   localparam int RC  = sadd_pkg::RCOLS;

   sadd_pkg::back_state_type state_ff, state_in;
   logic [TW-1:0] step_ff, step_in;

   logic [PW-1:0] lw_ff [WN][WN];
   logic [PW-1:0] rw_ff [WN][RC];

   logic [SW-1:0] sad_ff;
   logic          sad_ok_ff;
   logic [DW-1:0] sad_d_ff;
   logic [PW-1:0] best_ff;
   logic [DW-1:0] pick_ff;
   logic [sadd_pkg::X_W-1:0] cx_ff;
   logic [sadd_pkg::Y_W-1:0] cy_ff;

   logic          out_valid_ff, out_valid_in;
   logic [DW-1:0] out_disp_ff;
   logic [sadd_pkg::X_W-1:0] out_cx_ff;
   logic [sadd_pkg::Y_W-1:0] out_cy_ff;

   logic          pop, run, last, load_zero;
   logic [SW-1:0] sad_sum;
   logic [MW-1:0] prod;
   logic [PW-1:0] avg;

   assign pop_ready = (state_ff == sadd_pkg::BK_IDLE) && !out_valid_ff;
   assign pop  = pop_valid && pop_ready;
   assign run  = (state_ff == sadd_pkg::BK_RUN);
   assign last = (step_ff == TW'(RC - 1));
   assign load_zero = pop && pop_item.produce && !pop_item.do_match;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         sadd_pkg::BK_IDLE: begin
            step_in = '0;
            if (pop && pop_item.produce && pop_item.do_match) begin
               state_in = sadd_pkg::BK_RUN;
            end
         end
         sadd_pkg::BK_RUN: begin
            step_in = step_ff + TW'(1);
            if (last) begin
               state_in = sadd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = sadd_pkg::BK_IDLE;
         end
      endcase
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (load_zero || (run && last)) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sadd_pkg::BK_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // window shift on load, ring rotation while searching
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int r = 0; r < WN; r++) begin
            for (int k = WN - 1; k > 0; k--) begin
               lw_ff[r][k] <= lw_ff[r][k-1];
            end
            lw_ff[r][0] <= pop_item.lcol[r];
            for (int k = RC - 1; k > 0; k--) begin
               rw_ff[r][k] <= rw_ff[r][k-1];
            end
            rw_ff[r][0] <= pop_item.rcol[r];
         end
      end else if (run) begin
         for (int r = 0; r < WN; r++) begin
            for (int k = 0; k < RC - 1; k++) begin
               rw_ff[r][k] <= rw_ff[r][k+1];
            end
            rw_ff[r][RC-1] <= rw_ff[r][0];
         end
      end
   end

   always_comb begin
      sad_sum = '0;
      for (int r = 0; r < WN; r++) begin
         for (int c = 0; c < WN; c++) begin
            if (lw_ff[r][c] > rw_ff[r][c]) begin
               sad_sum = sad_sum + SW'(lw_ff[r][c] - rw_ff[r][c]);
            end else begin
               sad_sum = sad_sum + SW'(rw_ff[r][c] - lw_ff[r][c]);
            end
         end
      end
   end

   assign prod = MW'(sad_ff) * MW'(sadd_pkg::RECIP);
   assign avg  = prod[sadd_pkg::RECIP_SHIFT +: PW];

   always_ff @(posedge clock) begin
      if (pop) begin
         sad_ok_ff <= 1'b0;
         best_ff   <= PW'(sadd_pkg::START_MIN);
         pick_ff   <= '0;
         cx_ff     <= pop_item.cx;
         cy_ff     <= pop_item.cy;
      end else begin
         sad_ok_ff <= run && (step_ff < TW'(sadd_pkg::DISPARITIES));
         if (sad_ok_ff && (avg < best_ff)) begin
            best_ff <= avg;
            pick_ff <= sad_d_ff;
         end
      end
      sad_ff   <= sad_sum;
      sad_d_ff <= step_ff[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (load_zero) begin
         out_disp_ff <= '0;
         out_cx_ff   <= pop_item.cx;
         out_cy_ff   <= pop_item.cy;
      end else if (run && last) begin
         out_disp_ff <= pick_ff;
         out_cx_ff   <= cx_ff;
         out_cy_ff   <= cy_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.disparity = out_disp_ff;
   assign rsp_bus.centre_x  = out_cx_ff;
   assign rsp_bus.centre_y  = out_cy_ff;

   `SADD_ASSERT_IMP(a_pop_out_free, clock, reset, pop, !out_valid_ff, "load with result pending")
   `SADD_ASSERT_IMP(a_run_out_free, clock, reset, run, !out_valid_ff, "search with result pending")
   `SADD_ASSERT_NXT(a_run_ends_out, clock, reset, run && last, out_valid_ff, "search gave no result")
endmodule
`default_nettype wire

@@ rtl/core/stereo_sad_disparity.sv @@
// Top level of the stereo SAD disparity block: config register, front, queue, back.
// Depends on sadd_pkg, sadd_req_if, sadd_rsp_if, sadd_front, sadd_queue, sadd_back.
//
//   channel   dir  handshake          payload
//   req_bus   in   valid/ready        left_pixel, right_pixel, frame_start
//   rsp_bus   out  valid/ready        disparity, centre_x, centre_y
//   csr_*     in   write enable only  image_width (12 bits)
//
// Front takes no new pixel until the last is written (line store read, then read-modify-write).
// A centre that needs a search takes a window load, then ring rotations through the whole
// right window, one shift per cycle through the 25-input SAD tree; other loads take only the load.
// A result register holds each output; the next load waits until it has been taken.
// Reset is synchronous; line stores and windows are not cleared.
// A pending result blocks the back end only; the two-entry queue keeps the front moving until it fills.
`default_nettype none
module stereo_sad_disparity (
   input  wire logic                       clock,
   input  wire logic                       reset,
   sadd_req_if.sink                        req_bus,
   sadd_rsp_if.source                      rsp_bus,
   input  wire logic                       csr_write_enable,
   input  wire logic [sadd_pkg::CFG_W-1:0] csr_write_data
);
   logic [sadd_pkg::CFG_W-1:0] width_ff;
   logic                       fq_valid, fq_ready, qb_valid, qb_ready;
   sadd_pkg::col_item_type     fq_item, qb_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sadd_pkg::CFG_W'(sadd_pkg::WIDTH_RESET);
      end else if (csr_write_enable) begin
         width_ff <= csr_write_data;
      end
   end

   sadd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .width_cfg  (width_ff),
      .req_bus    (req_bus),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item)
   );

   sadd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   sadd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (qb_valid),
      .pop_ready (qb_ready),
      .pop_item  (qb_item),
      .rsp_bus   (rsp_bus)
   );
endmodule
`default_nettype wire
